### hw/rtl/i2e_pkg.sv
// Shared types and constants for the integer to English words unit.
`default_nettype none

package i2e_pkg;

  localparam int VALUE_W = 31;
  localparam int CODE_W  = 5;
  localparam int DIGITS  = 10;
  localparam int BCD_W   = 4 * DIGITS;
  // Two binary bits enter the BCD register per conversion step.
  localparam int BIN_W      = 32;
  localparam int CONV_STEPS = BIN_W / 2;
  localparam int CNT_W      = $clog2(CONV_STEPS);

  localparam logic [CODE_W-1:0] WORD_ZERO     = 5'd0;
  localparam logic [CODE_W-1:0] WORD_TEN      = 5'd10;
  localparam logic [CODE_W-1:0] WORD_TENS_OFS = 5'd18;
  localparam logic [CODE_W-1:0] WORD_HUNDRED  = 5'd28;
  localparam logic [CODE_W-1:0] WORD_THOUSAND = 5'd29;
  localparam logic [CODE_W-1:0] WORD_MILLION  = 5'd30;
  localparam logic [CODE_W-1:0] WORD_BILLION  = 5'd31;

  localparam logic [1:0] GRP_BILLION  = 2'd0;
  localparam logic [1:0] GRP_MILLION  = 2'd1;
  localparam logic [1:0] GRP_THOUSAND = 2'd2;
  localparam logic [1:0] GRP_UNITS    = 2'd3;

  typedef enum logic [2:0] {
    PH_HUND  = 3'd0,
    PH_HWORD = 3'd1,
    PH_REST  = 3'd2,
    PH_ONES  = 3'd3,
    PH_SCALE = 3'd4
  } phase_t;

  typedef struct packed {
    logic       load;
    logic       shift;
    logic       walk;
    logic       flush;
    logic [1:0] grp;
    phase_t     ph;
  } i2e_cmd_t;

  typedef struct packed {
    logic stall;
    logic out_free;
  } i2e_sts_t;

endpackage

`default_nettype wire

### hw/rtl/i2e_ctrl.sv
// Controller state machine: conversion steps, group and phase walk, final flush.
`default_nettype none

module i2e_ctrl
  import i2e_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire i2e_sts_t sts,
  output i2e_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       grp, grp_next;
  phase_t           ph, ph_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    grp_next   = grp;
    ph_next    = ph;
    cmd        = '0;
    cmd.grp    = grp;
    cmd.ph     = ph;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // Nothing is taken in while reset is held.
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt == CNT_W'(CONV_STEPS - 1)) begin
          grp_next   = GRP_BILLION;
          ph_next    = PH_HUND;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (!sts.stall) begin
          unique case (ph)
            PH_HUND:  ph_next = PH_HWORD;
            PH_HWORD: ph_next = PH_REST;
            PH_REST:  ph_next = PH_ONES;
            PH_ONES:  ph_next = PH_SCALE;
            default: begin
              ph_next = PH_HUND;
              if (grp == GRP_UNITS) begin
                state_next = ST_FLUSH;
              end else begin
                grp_next = grp + 1'b1;
              end
            end
          endcase
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      grp   <= GRP_BILLION;
      ph    <= PH_HUND;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      grp   <= grp_next;
      ph    <= ph_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/i2e_datapath.sv
// Datapath: binary to BCD shift register, word selection, pending word and output register.
`default_nettype none

module i2e_datapath
  import i2e_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [VALUE_W-1:0] value,
  input  wire i2e_cmd_t           cmd,
  output i2e_sts_t                sts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [CODE_W-1:0]       out_code,
  output logic                    out_last
);

  logic [BIN_W-1:0]  bin;
  logic [BCD_W-1:0]  bcd;
  logic              pend_valid;
  logic [CODE_W-1:0] pend_code;

  logic [3:0]        dig_h, dig_t, dig_o;
  logic              tok_hit;
  logic [CODE_W-1:0] tok_code;
  logic              out_free;
  logic              walk_go;

  // One double-dabble step: digits of five or more get three added, then a bit shifts in.
  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] b,
                                               input logic bit_in);
    logic [BCD_W-1:0] adj;
    adj = b;
    for (int d = 0; d < DIGITS; d++) begin
      if (b[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = b[4*d +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  always_comb begin
    unique case (cmd.grp)
      GRP_BILLION: begin
        dig_h = 4'd0;
        dig_t = 4'd0;
        dig_o = bcd[39:36];
      end
      GRP_MILLION: begin
        dig_h = bcd[35:32];
        dig_t = bcd[31:28];
        dig_o = bcd[27:24];
      end
      GRP_THOUSAND: begin
        dig_h = bcd[23:20];
        dig_t = bcd[19:16];
        dig_o = bcd[15:12];
      end
      default: begin
        dig_h = bcd[11:8];
        dig_t = bcd[7:4];
        dig_o = bcd[3:0];
      end
    endcase
  end

  always_comb begin
    tok_hit  = 1'b0;
    tok_code = WORD_ZERO;
    unique case (cmd.ph)
      PH_HUND: begin
        tok_hit  = (dig_h != 4'd0);
        tok_code = {1'b0, dig_h};
      end
      PH_HWORD: begin
        tok_hit  = (dig_h != 4'd0);
        tok_code = WORD_HUNDRED;
      end
      PH_REST: begin
        if (dig_t >= 4'd2) begin
          // Twenty and above start with a tens word, which also covers exactly twenty.
          tok_hit  = 1'b1;
          tok_code = WORD_TENS_OFS + {1'b0, dig_t};
        end else begin
          tok_hit  = (dig_t != 4'd0) || (dig_o != 4'd0);
          tok_code = dig_t[0] ? (WORD_TEN + {1'b0, dig_o}) : {1'b0, dig_o};
        end
      end
      PH_ONES: begin
        tok_hit  = (dig_t >= 4'd2) && (dig_o != 4'd0);
        tok_code = {1'b0, dig_o};
      end
      PH_SCALE: begin
        tok_hit = (cmd.grp != GRP_UNITS) &&
                  ((dig_h != 4'd0) || (dig_t != 4'd0) || (dig_o != 4'd0));
        unique case (cmd.grp)
          GRP_BILLION:  tok_code = WORD_BILLION;
          GRP_MILLION:  tok_code = WORD_MILLION;
          default:      tok_code = WORD_THOUSAND;
        endcase
      end
      default: begin
        tok_hit  = 1'b0;
        tok_code = WORD_ZERO;
      end
    endcase
  end

  assign out_free     = !out_valid || out_ready;
  // A word is held back one step so that the final one can be flagged at the flush.
  assign sts.stall    = tok_hit && pend_valid && !out_free;
  assign sts.out_free = out_free;
  assign walk_go      = cmd.walk && tok_hit && !sts.stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin <= {1'b0, value};
      bcd <= '0;
    end else if (cmd.shift) begin
      bin <= {bin[BIN_W-3:0], 2'b00};
      bcd <= dd_step(dd_step(bcd, bin[BIN_W-1]), bin[BIN_W-2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (walk_go && pend_valid) begin
        out_valid <= 1'b1;
      end else if (cmd.flush && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (walk_go) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush && out_free) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (walk_go) begin
      pend_code <= tok_code;
      if (pend_valid) begin
        out_code <= pend_code;
        out_last <= 1'b0;
      end
    end else if (cmd.flush && out_free) begin
      // With no word pending, the value was zero.
      out_code <= pend_valid ? pend_code : WORD_ZERO;
      out_last <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/integer_to_english_words_unit.sv
// Top level of the integer to English words unit.
// Each value passes through an accept, 16 BCD conversion steps at two bits each,
// a 20-step walk over four groups of five phases and a final flush; a new value
// is taken only after the flush, and the walk and flush wait while the output is stalled.
// Words leave at most one a cycle.
// Reset (rst, synchronous) empties the output and pending word and returns to idle.
`default_nettype none

module integer_to_english_words_unit
  import i2e_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [30:0] value, [31] zero fill
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [4:0] word_code, [7:5] zero fill
  output logic             m_tlast    // last_word
);

  i2e_cmd_t          cmd;
  i2e_sts_t          sts;
  logic [CODE_W-1:0] code;

  i2e_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  i2e_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (s_tdata[VALUE_W-1:0]),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_code  (code),
    .out_last  (m_tlast)
  );

  assign m_tdata = {3'b000, code};

endmodule

`default_nettype wire

### hw/rtl/i2e_checker.sv
// Port-level assertions for the integer to English words unit, bound to the top level.
`default_nettype none

module i2e_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic        m_tlast
);

  // A word waiting for the sink holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // One value is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a value is in progress");

  // Zero is only ever spoken alone.
  a_zero_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[4:0] == 5'd0) |-> m_tlast)
    else $error("zero word not flagged as last");

  // The fill bits above the word code stay clear.
  a_fill_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:5] == 3'b000))
    else $error("output fill bits set");

endmodule

bind integer_to_english_words_unit i2e_checker u_i2e_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
